// ----- hw/rtl/lebc_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package lebc_pkg;

   localparam int CAPACITY = 64;
   localparam int ADDR_W   = $clog2(CAPACITY);
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int ACT_W    = 4;
   localparam int CHAR_W   = 8;
   localparam int OFF_W    = 8;
   localparam int POS_W    = ((CNT_W > OFF_W) ? CNT_W : OFF_W) + 2;

   localparam logic [ACT_W-1:0] ACT_INSERT    = ACT_W'(0);
   localparam logic [ACT_W-1:0] ACT_DELETE    = ACT_W'(1);
   localparam logic [ACT_W-1:0] ACT_BACKSPACE = ACT_W'(2);
   localparam logic [ACT_W-1:0] ACT_LEFT      = ACT_W'(3);
   localparam logic [ACT_W-1:0] ACT_RIGHT     = ACT_W'(4);
   localparam logic [ACT_W-1:0] ACT_CLEAR     = ACT_W'(5);
   localparam logic [ACT_W-1:0] ACT_PEEK      = ACT_W'(6);
   localparam logic [ACT_W-1:0] ACT_DIST_PREV = ACT_W'(7);
   localparam logic [ACT_W-1:0] ACT_DIST_NEXT = ACT_W'(8);

   // How the datapath prepares its walk pointer when an action is accepted.
   typedef enum logic [2:0] {
      SETUP_NONE,
      SETUP_INS,
      SETUP_DEL,
      SETUP_BSP,
      SETUP_BACK,
      SETUP_FWD,
      SETUP_PEEK
   } setup_type;

   // Which result the datapath produces and which state update it commits.
   typedef enum logic [2:0] {
      FIN_NONE,
      FIN_FAIL,
      FIN_LEFT,
      FIN_RIGHT,
      FIN_CLEAR,
      FIN_WALK,
      FIN_PEEK
   } fin_type;

   typedef struct packed {
      setup_type setup;
      logic      step;
      logic      peek_rd;
      fin_type   fin;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic cur_zero;
      logic cur_end;
      logic walk_done;
   } status_type;

endpackage

`default_nettype wire

// ----- hw/rtl/lebc_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none

module lebc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/lebc_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none

module lebc_ctrl (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [lebc_pkg::ACT_W-1:0]  req_action,
   input  lebc_pkg::status_type        status,
   output logic                        busy,
   output lebc_pkg::cmd_type           cmd
);
   import lebc_pkg::*;

   typedef enum logic [1:0] {
      S_IDLE,
      S_WALK,
      S_PEEK_RD,
      S_PEEK_FIN
   } state_type;

   state_type state_ff, state_in;
   logic      busy_ff;

   always_comb begin
      state_in    = state_ff;
      cmd.setup   = SETUP_NONE;
      cmd.step    = 1'b0;
      cmd.peek_rd = 1'b0;
      cmd.fin     = FIN_NONE;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               case (req_action)
                  ACT_INSERT: begin
                     if (status.full) begin
                        cmd.fin = FIN_FAIL;
                     end else begin
                        cmd.setup = SETUP_INS;
                        state_in  = S_WALK;
                     end
                  end
                  ACT_DELETE: begin
                     if (status.cur_end) begin
                        cmd.fin = FIN_FAIL;
                     end else begin
                        cmd.setup = SETUP_DEL;
                        state_in  = S_WALK;
                     end
                  end
                  ACT_BACKSPACE: begin
                     if (status.cur_zero) begin
                        cmd.fin = FIN_FAIL;
                     end else begin
                        cmd.setup = SETUP_BSP;
                        state_in  = S_WALK;
                     end
                  end
                  ACT_LEFT: begin
                     cmd.fin = status.cur_zero ? FIN_FAIL : FIN_LEFT;
                  end
                  ACT_RIGHT: begin
                     // Stepping right is refused on a full buffer as well.
                     cmd.fin = (status.cur_end || status.full) ? FIN_FAIL : FIN_RIGHT;
                  end
                  ACT_CLEAR: begin
                     cmd.fin = FIN_CLEAR;
                  end
                  ACT_PEEK: begin
                     cmd.setup = SETUP_PEEK;
                     state_in  = S_PEEK_RD;
                  end
                  ACT_DIST_PREV: begin
                     cmd.setup = SETUP_BACK;
                     state_in  = S_WALK;
                  end
                  ACT_DIST_NEXT: begin
                     cmd.setup = SETUP_FWD;
                     state_in  = S_WALK;
                  end
                  default: begin
                     cmd.fin = FIN_FAIL;
                  end
               endcase
            end
         end
         S_WALK: begin
            if (status.walk_done) begin
               cmd.fin  = FIN_WALK;
               state_in = S_IDLE;
            end else begin
               cmd.step = 1'b1;
            end
         end
         S_PEEK_RD: begin
            cmd.peek_rd = 1'b1;
            state_in    = S_PEEK_FIN;
         end
         S_PEEK_FIN: begin
            cmd.fin  = FIN_PEEK;
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         busy_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         busy_ff  <= (state_in != S_IDLE);
      end
   end

   assign busy = busy_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/lebc_dp.sv -----
`timescale 1ns / 1ps
`default_nettype none

module lebc_dp (
   input  logic                               clock,
   input  logic                               reset,
   input  lebc_pkg::cmd_type                  cmd,
   input  logic [lebc_pkg::CHAR_W-1:0]        req_char_value,
   input  logic signed [lebc_pkg::OFF_W-1:0]  req_offset,
   output lebc_pkg::status_type               status,
   output logic                               rsp_strobe,
   output logic                               rsp_ok,
   output logic [lebc_pkg::CHAR_W-1:0]        rsp_char_out,
   output logic [lebc_pkg::CNT_W-1:0]         rsp_distance,
   output logic [lebc_pkg::CNT_W-1:0]         rsp_cursor_pos,
   output logic [lebc_pkg::CNT_W-1:0]         rsp_length,
   output logic                               rsp_is_full,
   output logic                               rsp_empty
);
   import lebc_pkg::*;

   // Architectural state.
   logic [CNT_W-1:0]  used_ff, used_in;
   logic [CNT_W-1:0]  cursor_ff, cursor_in;

   // Walk machinery: ptr_ff runs toward lim_ff, one RAM read per step.
   logic [CNT_W-1:0]  ptr_ff;
   logic [CNT_W-1:0]  lim_ff;
   logic              down_ff;
   logic              cmp_ff;
   logic              pend_ff;
   logic [ADDR_W-1:0] raddr_ff;
   logic [CNT_W-1:0]  cnt_ff;
   logic [CHAR_W-1:0] chr_ff;
   setup_type         kind_ff;
   logic              in_range_ff;

   // Result registers.
   logic              strobe_ff;
   logic              ok_ff;
   logic [CHAR_W-1:0] char_out_ff;
   logic [CNT_W-1:0]  dist_ff;

   logic              more;
   logic [CNT_W-1:0]  ptr_dec;
   logic [CNT_W-1:0]  ptr_inc;
   logic [ADDR_W-1:0] walk_addr;
   logic              ins_fin;
   logic              fin_ok;
   logic [CHAR_W-1:0] fin_char;
   logic [CNT_W-1:0]  fin_dist;
   logic signed [POS_W-1:0] peek_pos;
   logic              peek_in_range;

   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [CHAR_W-1:0] wr_data;
   logic [ADDR_W-1:0] rd_addr;
   logic [CHAR_W-1:0] rd_data;

   lebc_ram #(
      .WIDTH (CHAR_W),
      .DEPTH (CAPACITY)
   ) u_text_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      more      = (ptr_ff != lim_ff);
      ptr_dec   = ptr_ff - CNT_W'(1);
      ptr_inc   = ptr_ff + CNT_W'(1);
      walk_addr = down_ff ? ptr_dec[ADDR_W-1:0] : ptr_ff[ADDR_W-1:0];
      rd_addr   = cmd.peek_rd ? ptr_ff[ADDR_W-1:0] : walk_addr;

      // Inserting walks downward and copies each byte one place up; deleting
      // walks upward and copies each byte one place down.
      ins_fin = (cmd.fin == FIN_WALK) && (kind_ff == SETUP_INS);
      wr_en   = (cmd.step && pend_ff && !cmp_ff) || ins_fin;
      if (ins_fin) begin
         wr_addr = cursor_ff[ADDR_W-1:0];
         wr_data = chr_ff;
      end else begin
         wr_addr = down_ff ? (raddr_ff + ADDR_W'(1)) : (raddr_ff - ADDR_W'(1));
         wr_data = rd_data;
      end

      peek_pos = $signed({{(POS_W-CNT_W){1'b0}}, cursor_ff})
               + $signed({{(POS_W-OFF_W){req_offset[OFF_W-1]}}, req_offset});
      peek_in_range = !peek_pos[POS_W-1]
                    && (peek_pos[POS_W-2:0] < {{(POS_W-1-CNT_W){1'b0}}, used_ff});

      status.full      = (used_ff == CNT_W'(CAPACITY));
      status.cur_zero  = (cursor_ff == '0);
      status.cur_end   = (cursor_ff == used_ff);
      status.walk_done = (!more && !pend_ff) || (pend_ff && cmp_ff && (rd_data == chr_ff));
   end

   always_comb begin
      used_in   = used_ff;
      cursor_in = cursor_ff;
      fin_ok    = 1'b0;
      fin_char  = '0;
      fin_dist  = '0;
      case (cmd.fin)
         FIN_LEFT: begin
            cursor_in = cursor_ff - CNT_W'(1);
            fin_ok    = 1'b1;
         end
         FIN_RIGHT: begin
            cursor_in = cursor_ff + CNT_W'(1);
            fin_ok    = 1'b1;
         end
         FIN_CLEAR: begin
            used_in   = '0;
            cursor_in = '0;
            fin_ok    = 1'b1;
         end
         FIN_PEEK: begin
            fin_char = in_range_ff ? rd_data : '0;
            fin_ok   = 1'b1;
         end
         FIN_WALK: begin
            fin_ok = 1'b1;
            case (kind_ff)
               SETUP_INS: begin
                  cursor_in = cursor_ff + CNT_W'(1);
                  used_in   = used_ff + CNT_W'(1);
               end
               SETUP_DEL: begin
                  used_in = used_ff - CNT_W'(1);
               end
               SETUP_BSP: begin
                  cursor_in = cursor_ff - CNT_W'(1);
                  used_in   = used_ff - CNT_W'(1);
               end
               SETUP_BACK, SETUP_FWD: begin
                  fin_dist = cnt_ff;
               end
               default: begin
               end
            endcase
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff   <= '0;
         cursor_ff <= '0;
         pend_ff   <= 1'b0;
         strobe_ff <= 1'b0;
      end else begin
         used_ff   <= used_in;
         cursor_ff <= cursor_in;
         strobe_ff <= (cmd.fin != FIN_NONE);
         if (cmd.setup != SETUP_NONE) begin
            pend_ff <= 1'b0;
         end else if (cmd.step) begin
            pend_ff <= more;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.setup != SETUP_NONE) begin
         kind_ff     <= cmd.setup;
         chr_ff      <= req_char_value;
         cnt_ff      <= '0;
         in_range_ff <= peek_in_range;
         case (cmd.setup)
            SETUP_INS: begin
               ptr_ff  <= used_ff;
               lim_ff  <= cursor_ff;
               down_ff <= 1'b1;
               cmp_ff  <= 1'b0;
            end
            SETUP_DEL: begin
               ptr_ff  <= cursor_ff + CNT_W'(1);
               lim_ff  <= used_ff;
               down_ff <= 1'b0;
               cmp_ff  <= 1'b0;
            end
            SETUP_BSP: begin
               ptr_ff  <= cursor_ff;
               lim_ff  <= used_ff;
               down_ff <= 1'b0;
               cmp_ff  <= 1'b0;
            end
            SETUP_BACK: begin
               ptr_ff  <= cursor_ff;
               lim_ff  <= '0;
               down_ff <= 1'b1;
               cmp_ff  <= 1'b1;
            end
            SETUP_FWD: begin
               ptr_ff  <= cursor_ff;
               lim_ff  <= used_ff;
               down_ff <= 1'b0;
               cmp_ff  <= 1'b1;
            end
            SETUP_PEEK: begin
               ptr_ff <= peek_pos[CNT_W-1:0];
            end
            default: begin
            end
         endcase
      end else if (cmd.step) begin
         if (more) begin
            ptr_ff   <= down_ff ? ptr_dec : ptr_inc;
            raddr_ff <= walk_addr;
         end
         // A compare that matched ends the walk, so each counted step is a miss.
         if (pend_ff && cmp_ff) begin
            cnt_ff <= cnt_ff + CNT_W'(1);
         end
      end

      if (cmd.fin != FIN_NONE) begin
         ok_ff       <= fin_ok;
         char_out_ff <= fin_char;
         dist_ff     <= fin_dist;
      end
   end

   assign rsp_strobe     = strobe_ff;
   assign rsp_ok         = ok_ff;
   assign rsp_char_out   = char_out_ff;
   assign rsp_distance   = dist_ff;
   assign rsp_cursor_pos = cursor_ff;
   assign rsp_length     = used_ff;
   assign rsp_is_full    = status.full;
   assign rsp_empty      = (used_ff == '0);

endmodule

`default_nettype wire

// ----- hw/rtl/line_edit_buffer_with_cursor.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Line-edit buffer of up to 64 bytes with a cursor. An action is taken when start is high
// and busy is low; its one result appears for a single cycle with rsp_strobe high and must
// be captured then. Left, right, clear, refused edits and unknown action codes answer in the
// cycle after acceptance and leave busy low, so one may follow every cycle. All other work
// walks the text RAM, which has separate read and write ports, one byte per cycle while
// busy is high: peek reads one byte; insert, delete and backspace shift bytes one place
// until none is left to move; a distance query stops at the first byte that matches its
// character or once every byte it searches has missed. The result strobe follows in the
// cycle busy falls.

module line_edit_buffer_with_cursor (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic [lebc_pkg::ACT_W-1:0]         req_action,
   input  logic [lebc_pkg::CHAR_W-1:0]        req_char_value,
   input  logic signed [lebc_pkg::OFF_W-1:0]  req_offset,
   output logic                               rsp_strobe,
   output logic                               rsp_ok,
   output logic [lebc_pkg::CHAR_W-1:0]        rsp_char_out,
   output logic [lebc_pkg::CNT_W-1:0]         rsp_distance,
   output logic [lebc_pkg::CNT_W-1:0]         rsp_cursor_pos,
   output logic [lebc_pkg::CNT_W-1:0]         rsp_length,
   output logic                               rsp_is_full,
   output logic                               rsp_empty
);
   import lebc_pkg::*;

   cmd_type    cmd;
   status_type status;

   lebc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_action (req_action),
      .status     (status),
      .busy       (busy),
      .cmd        (cmd)
   );

   lebc_dp u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .req_char_value (req_char_value),
      .req_offset     (req_offset),
      .status         (status),
      .rsp_strobe     (rsp_strobe),
      .rsp_ok         (rsp_ok),
      .rsp_char_out   (rsp_char_out),
      .rsp_distance   (rsp_distance),
      .rsp_cursor_pos (rsp_cursor_pos),
      .rsp_length     (rsp_length),
      .rsp_is_full    (rsp_is_full),
      .rsp_empty      (rsp_empty)
   );

endmodule

`default_nettype wire

// ----- hw/rtl/lebc_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none

module lebc_checker (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic                               busy,
   input  logic                               rsp_strobe,
   input  logic [lebc_pkg::CNT_W-1:0]         rsp_cursor_pos,
   input  logic [lebc_pkg::CNT_W-1:0]         rsp_length,
   input  logic                               rsp_is_full,
   input  logic                               rsp_empty
);

   // A result beat is only ever shown once the block has gone idle.
   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("result beat while busy");

   // An accepted action either makes the block busy or brings a result beat.
   a_accept_answers: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy || rsp_strobe))
      else $error("accepted action neither busy nor answered");

   // Length and cursor move only together with a result beat.
   a_state_quiet: assert property (@(posedge clock) disable iff (reset)
      (!rsp_strobe && !$past(reset)) |-> ($stable(rsp_length) && $stable(rsp_cursor_pos)))
      else $error("length or cursor changed without a result");

   a_cursor_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_cursor_pos <= rsp_length)
      else $error("cursor beyond end of text");

   a_flags: assert property (@(posedge clock) disable iff (reset)
      !(rsp_is_full && rsp_empty))
      else $error("buffer reported both full and empty");

endmodule

bind line_edit_buffer_with_cursor lebc_checker u_lebc_checker (.*);

`default_nettype wire
